FILE: design/hbmc_pkg.sv
package hbmc_pkg;

  // Geometry limits
  localparam int MAX_COLUMNS = 4096;
  localparam int MAX_ROWS    = 4096;

  // Field and state widths
  localparam int CH_W    = 8;
  localparam int HUE_W   = 9;
  localparam int LW_W    = 13;
  localparam int POS_W   = 12;
  localparam int CNT_W   = 25;
  localparam int SUM_W   = 36;
  localparam int CENT_W  = 12;
  localparam int ITER_W  = 6;

  // Divider sizing: hue dividend is 60*num, num below 256, so 14 bits
  localparam int DVD_W    = SUM_W;
  localparam int DVS_W    = CNT_W;
  localparam int HUE_DVD_W = 14;

  // Saturation limits
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [POS_W-1:0] ROW_LAST  = POS_W'(MAX_ROWS - 1);

  // Sector base hues
  localparam logic [HUE_W-1:0] BASE_0   = 9'd0;
  localparam logic [HUE_W-1:0] BASE_60  = 9'd60;
  localparam logic [HUE_W-1:0] BASE_120 = 9'd120;
  localparam logic [HUE_W-1:0] BASE_180 = 9'd180;
  localparam logic [HUE_W-1:0] BASE_240 = 9'd240;
  localparam logic [HUE_W-1:0] BASE_300 = 9'd300;

  // Register indexes
  localparam logic [1:0] REG_HUE_LOW    = 2'd0;
  localparam logic [1:0] REG_HUE_HIGH   = 2'd1;
  localparam logic [1:0] REG_LINE_WIDTH = 2'd2;

  // Request to the shared divider
  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;  // left aligned: first bit used is the MSB
    logic [DVS_W-1:0]  divisor;
    logic [ITER_W-1:0] nbits;     // quotient bits to produce
  } div_req_t;

endpackage

FILE: design/hbmc_div.sv
// Restoring divider, one quotient bit per cycle
module hbmc_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  hbmc_pkg::div_req_t             req,
  output logic                           done,
  output logic [hbmc_pkg::DVD_W-1:0]     quotient
);

  logic                          busy_r;
  logic                          done_r;
  logic [hbmc_pkg::ITER_W-1:0]   cnt_r;
  logic [hbmc_pkg::DVS_W-1:0]    rem_r;
  logic [hbmc_pkg::DVD_W-1:0]    dvd_r;
  logic [hbmc_pkg::DVD_W-1:0]    q_r;
  logic [hbmc_pkg::DVS_W-1:0]    dvs_r;

  logic [hbmc_pkg::DVS_W:0]      trial;
  logic [hbmc_pkg::DVS_W:0]      diff;
  logic                          ge;
  logic [hbmc_pkg::DVS_W-1:0]    rem_nxt;

  // Shift in next dividend bit and try a subtract
  always_comb begin
    trial   = {rem_r, dvd_r[hbmc_pkg::DVD_W-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? diff[hbmc_pkg::DVS_W-1:0] : trial[hbmc_pkg::DVS_W-1:0];
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == hbmc_pkg::ITER_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      dvd_r <= req.dividend;
      dvs_r <= req.divisor;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[hbmc_pkg::DVD_W-2:0], 1'b0};
      q_r   <= {q_r[hbmc_pkg::DVD_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: design/hue_band_mask_centroid.sv
// Hue band mask and centroid.
// Input channel (in_valid / in_stall) takes one RGB pixel per request in
// raster order; in_frame_last marks the final pixel of a frame. Each pixel
// gives one result on the output channel (out_valid / out_stall): its hue
// (0..359, gray is 0), the in-band flag, and on the last pixel the frame's
// in-band count and centroid, which are 0 on other pixels.
// The band and the line width are set through cfg_valid / cfg_ready with
// cfg_index / cfg_data; the user must do so only while the block is idle,
// as the block does not enforce it. cfg_ready is always 1. One pixel is
// processed at a time. A colored pixel runs the 14-step hue division in
// the shared radix-2 divider; a gray pixel skips the division. The next
// request is taken in the cycle after the result is loaded. The last pixel
// of a frame adds two 36-step centroid divisions on the same divider; both
// are skipped when the frame has no in-band pixel.
// The result sits in an output register, so the next pixel is accepted
// while a result is stalled; a finished pixel waits until that register is
// free. Reset (rst_n low, synchronous) restores the band 40..80, a width of
// 320 and clears position and accumulators.
module hue_band_mask_centroid (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [hbmc_pkg::CH_W-1:0]       in_red,
  input  logic [hbmc_pkg::CH_W-1:0]       in_green,
  input  logic [hbmc_pkg::CH_W-1:0]       in_blue,
  input  logic                            in_frame_last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [hbmc_pkg::HUE_W-1:0]      out_hue,
  output logic                            out_in_band,
  output logic                            out_frame_done,
  output logic [hbmc_pkg::CNT_W-1:0]      out_match_count,
  output logic [hbmc_pkg::CENT_W-1:0]     out_centroid_x,
  output logic [hbmc_pkg::CENT_W-1:0]     out_centroid_y,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [hbmc_pkg::LW_W-1:0]       cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_HS   = 4'd1;
  localparam logic [3:0] S_HW   = 4'd2;
  localparam logic [3:0] S_ACC  = 4'd3;
  localparam logic [3:0] S_CXS  = 4'd4;
  localparam logic [3:0] S_CXW  = 4'd5;
  localparam logic [3:0] S_CYS  = 4'd6;
  localparam logic [3:0] S_CYW  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0]                      state_r;

  logic [hbmc_pkg::HUE_W-1:0]      hue_low_r;
  logic [hbmc_pkg::HUE_W-1:0]      hue_high_r;
  logic [hbmc_pkg::LW_W-1:0]       line_width_r;

  logic [hbmc_pkg::POS_W-1:0]      column_r;
  logic [hbmc_pkg::POS_W-1:0]      row_r;
  logic [hbmc_pkg::CNT_W-1:0]      band_count_r;
  logic [hbmc_pkg::SUM_W-1:0]      column_sum_r;
  logic [hbmc_pkg::SUM_W-1:0]      row_sum_r;

  logic [hbmc_pkg::HUE_W-1:0]      base_r;
  logic [hbmc_pkg::CH_W-1:0]       num_r;
  logic [hbmc_pkg::CH_W-1:0]       den_r;
  logic                            last_r;
  logic [hbmc_pkg::HUE_W-1:0]      hue_r;
  logic                            hit_r;
  logic [hbmc_pkg::CENT_W-1:0]     cx_r;
  logic [hbmc_pkg::CENT_W-1:0]     cy_r;

  logic                            out_valid_r;
  logic [hbmc_pkg::HUE_W-1:0]      out_hue_r;
  logic                            out_in_band_r;
  logic                            out_frame_done_r;
  logic [hbmc_pkg::CNT_W-1:0]      out_match_count_r;
  logic [hbmc_pkg::CENT_W-1:0]     out_centroid_x_r;
  logic [hbmc_pkg::CENT_W-1:0]     out_centroid_y_r;

  logic [hbmc_pkg::HUE_W-1:0]      base_nxt;
  logic [hbmc_pkg::CH_W-1:0]       num_nxt;
  logic [hbmc_pkg::CH_W-1:0]       den_nxt;
  logic [hbmc_pkg::HUE_DVD_W-1:0]  num60;
  logic [hbmc_pkg::HUE_W-1:0]      hue_nxt;
  logic [hbmc_pkg::LW_W-1:0]       width_eff;
  logic                            wrap;
  logic [hbmc_pkg::SUM_W:0]        csum_add;
  logic [hbmc_pkg::SUM_W:0]        rsum_add;
  logic [hbmc_pkg::CENT_W-1:0]     cent_nxt;
  logic                            out_free;

  hbmc_pkg::div_req_t              div_req;
  logic                            div_done;
  logic [hbmc_pkg::DVD_W-1:0]      div_q;

  hbmc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  // Sector select: base hue and the fraction num/den
  always_comb begin
    base_nxt = hbmc_pkg::BASE_0;
    num_nxt  = '0;
    den_nxt  = '0;
    if (in_red > in_green && in_green >= in_blue) begin
      base_nxt = hbmc_pkg::BASE_0;
      num_nxt  = in_green - in_blue;
      den_nxt  = in_red - in_blue;
    end else if (in_green >= in_red && in_red > in_blue) begin
      base_nxt = hbmc_pkg::BASE_60;
      num_nxt  = in_green - in_red;
      den_nxt  = in_green - in_blue;
    end else if (in_green > in_blue && in_blue >= in_red) begin
      base_nxt = hbmc_pkg::BASE_120;
      num_nxt  = in_blue - in_red;
      den_nxt  = in_green - in_red;
    end else if (in_blue >= in_green && in_green > in_red) begin
      base_nxt = hbmc_pkg::BASE_180;
      num_nxt  = in_blue - in_green;
      den_nxt  = in_blue - in_red;
    end else if (in_blue > in_red && in_red >= in_green) begin
      base_nxt = hbmc_pkg::BASE_240;
      num_nxt  = in_red - in_green;
      den_nxt  = in_blue - in_green;
    end else if (in_red >= in_blue && in_blue > in_green) begin
      base_nxt = hbmc_pkg::BASE_300;
      num_nxt  = in_red - in_blue;
      den_nxt  = in_red - in_green;
    end
  end

  // 60*num as shift and subtract
  assign num60 = ({6'd0, num_r} << 6) - ({6'd0, num_r} << 2);

  // Divider requests
  always_comb begin
    div_req = '0;
    case (state_r)
      S_HS: begin
        div_req.start    = den_r != '0;
        div_req.dividend = {num60, {(hbmc_pkg::DVD_W - hbmc_pkg::HUE_DVD_W){1'b0}}};
        div_req.divisor  = {{(hbmc_pkg::DVS_W - hbmc_pkg::CH_W){1'b0}}, den_r};
        div_req.nbits    = hbmc_pkg::ITER_W'(hbmc_pkg::HUE_DVD_W);
      end
      S_CXS: begin
        div_req.start    = band_count_r != '0;
        div_req.dividend = column_sum_r;
        div_req.divisor  = band_count_r;
        div_req.nbits    = hbmc_pkg::ITER_W'(hbmc_pkg::DVD_W);
      end
      S_CYS: begin
        div_req.start    = band_count_r != '0;
        div_req.dividend = row_sum_r;
        div_req.divisor  = band_count_r;
        div_req.nbits    = hbmc_pkg::ITER_W'(hbmc_pkg::DVD_W);
      end
      default: div_req = '0;
    endcase
  end

  // Hue, position and accumulator helpers
  always_comb begin
    hue_nxt = base_r + {3'd0, div_q[5:0]};
    if (line_width_r == '0)
      width_eff = hbmc_pkg::LW_W'(1);
    else if (line_width_r > hbmc_pkg::LW_W'(hbmc_pkg::MAX_COLUMNS))
      width_eff = hbmc_pkg::LW_W'(hbmc_pkg::MAX_COLUMNS);
    else
      width_eff = line_width_r;
    wrap     = ({1'b0, column_r} + hbmc_pkg::LW_W'(1)) >= width_eff;
    csum_add = {1'b0, column_sum_r} + {{(hbmc_pkg::SUM_W + 1 - hbmc_pkg::POS_W){1'b0}}, column_r};
    rsum_add = {1'b0, row_sum_r} + {{(hbmc_pkg::SUM_W + 1 - hbmc_pkg::POS_W){1'b0}}, row_r};
    // clamp quotient to 12 bits
    if (div_q[hbmc_pkg::DVD_W-1:hbmc_pkg::CENT_W] != '0)
      cent_nxt = {hbmc_pkg::CENT_W{1'b1}};
    else
      cent_nxt = div_q[hbmc_pkg::CENT_W-1:0];
  end

  assign out_free = !out_valid_r || !out_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_low_r    <= 9'd40;
      hue_high_r   <= 9'd80;
      line_width_r <= 13'd320;
    end else if (cfg_valid) begin
      case (cfg_index)
        hbmc_pkg::REG_HUE_LOW:    hue_low_r    <= cfg_data[hbmc_pkg::HUE_W-1:0];
        hbmc_pkg::REG_HUE_HIGH:   hue_high_r   <= cfg_data[hbmc_pkg::HUE_W-1:0];
        hbmc_pkg::REG_LINE_WIDTH: line_width_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer, position and frame accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      column_r     <= '0;
      row_r        <= '0;
      band_count_r <= '0;
      column_sum_r <= '0;
      row_sum_r    <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_HS;
        end
        S_HS: begin
          state_r <= (den_r != '0) ? S_HW : S_ACC;
        end
        S_HW: begin
          if (div_done) state_r <= S_ACC;
        end
        S_ACC: begin
          if (hit_r) begin
            if (band_count_r != hbmc_pkg::COUNT_MAX) band_count_r <= band_count_r + 1'b1;
            column_sum_r <= csum_add[hbmc_pkg::SUM_W] ? hbmc_pkg::SUM_MAX
                                                      : csum_add[hbmc_pkg::SUM_W-1:0];
            row_sum_r    <= rsum_add[hbmc_pkg::SUM_W] ? hbmc_pkg::SUM_MAX
                                                      : rsum_add[hbmc_pkg::SUM_W-1:0];
          end
          if (last_r) begin
            state_r <= S_CXS;
          end else begin
            state_r <= S_FIN;
            if (wrap) begin
              column_r <= '0;
              if (row_r != hbmc_pkg::ROW_LAST) row_r <= row_r + 1'b1;
            end else begin
              column_r <= column_r + 1'b1;
            end
          end
        end
        S_CXS: begin
          state_r <= (band_count_r != '0) ? S_CXW : S_CYS;
        end
        S_CXW: begin
          if (div_done) state_r <= S_CYS;
        end
        S_CYS: begin
          state_r <= (band_count_r != '0) ? S_CYW : S_FIN;
        end
        S_CYW: begin
          if (div_done) state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state_r <= S_IDLE;
            if (last_r) begin
              band_count_r <= '0;
              column_sum_r <= '0;
              row_sum_r    <= '0;
              column_r     <= '0;
              row_r        <= '0;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Per-pixel working registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          base_r <= base_nxt;
          num_r  <= num_nxt;
          den_r  <= den_nxt;
          last_r <= in_frame_last;
          cx_r   <= '0;
          cy_r   <= '0;
        end
      end
      S_HS: begin
        hue_r <= base_r;
        hit_r <= base_r >= hue_low_r && base_r <= hue_high_r;
      end
      S_HW: begin
        if (div_done) begin
          hue_r <= hue_nxt;
          hit_r <= hue_nxt >= hue_low_r && hue_nxt <= hue_high_r;
        end
      end
      S_CXW: begin
        if (div_done) cx_r <= cent_nxt;
      end
      S_CYW: begin
        if (div_done) cy_r <= cent_nxt;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      out_hue_r         <= hue_r;
      out_in_band_r     <= hit_r;
      out_frame_done_r  <= last_r;
      out_match_count_r <= last_r ? band_count_r : '0;
      out_centroid_x_r  <= cx_r;
      out_centroid_y_r  <= cy_r;
    end
  end

  assign in_stall        = state_r != S_IDLE;
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_hue         = out_hue_r;
  assign out_in_band     = out_in_band_r;
  assign out_frame_done  = out_frame_done_r;
  assign out_match_count = out_match_count_r;
  assign out_centroid_x  = out_centroid_x_r;
  assign out_centroid_y  = out_centroid_y_r;

endmodule
